FILE: rtl/grr_pkg.sv
package grr_pkg;

    localparam int ROW_PIXELS        = 8;
    localparam int BASELINE_BIAS     = 9;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam int COORD_IN_W  = 11;
    localparam int COORD_OUT_W = 13;
    localparam int CLIP_DIM_W  = 10;
    localparam int FONT_H_W    = 5;
    localparam int SCALE_W     = 4;
    localparam int NIBBLE_W    = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;

    localparam logic [FONT_H_W-1:0]   FONT_HEIGHT_RST = 5'd8;
    localparam logic [SCALE_W-1:0]    SCALE_RST       = 4'd1;
    localparam logic [CLIP_DIM_W-1:0] CLIP_DIM_RST    = 10'd1023;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FONT_HEIGHT = 3'd0,
        CFG_SCALE       = 3'd1,
        CFG_CLIP_ENABLE = 3'd2,
        CFG_CLIP_X      = 3'd3,
        CFG_CLIP_Y      = 3'd4,
        CFG_CLIP_W      = 3'd5,
        CFG_CLIP_H      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [FONT_H_W-1:0]          font_height;
        logic [SCALE_W-1:0]           scale;
        logic                         clip_enable;
        logic signed [COORD_IN_W-1:0] clip_x;
        logic signed [COORD_IN_W-1:0] clip_y;
        logic [CLIP_DIM_W-1:0]        clip_w;
        logic [CLIP_DIM_W-1:0]        clip_h;
    } t_cfg;

    // one glyph row after classification: surviving pixels only
    typedef struct packed {
        logic signed [COORD_IN_W-1:0]  ox;
        logic signed [COORD_OUT_W-1:0] py;
        logic [ROW_PIXELS-1:0]         mask;
    } t_job;

endpackage

FILE: rtl/grr_intf.sv
interface grr_in_if;
    import grr_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [COORD_IN_W-1:0] origin_x;
    logic signed [COORD_IN_W-1:0] origin_y;
    logic [NIBBLE_W-1:0]          glyph_width;
    logic [NIBBLE_W-1:0]          row_index;
    logic [ROW_PIXELS-1:0]        row_bits;

    modport source(output valid, origin_x, origin_y, glyph_width, row_index, row_bits,
                   input ready);
    modport sink(input valid, origin_x, origin_y, glyph_width, row_index, row_bits,
                 output ready);
endinterface

interface grr_out_if;
    import grr_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_OUT_W-1:0] pixel_x;
    logic signed [COORD_OUT_W-1:0] pixel_y;
    logic [SCALE_W-1:0]            square_side;
    logic                          last_in_row;

    modport source(output valid, pixel_x, pixel_y, square_side, last_in_row, input ready);
    modport sink(input valid, pixel_x, pixel_y, square_side, last_in_row, output ready);
endinterface

interface grr_cfg_if;
    import grr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/glyph_row_rasterizer.sv
// A row passes from the classifier through the queue and the emitter's row registers
// to the registered output. Throughput: one pixel per cycle while the output is ready.
// The single emitter sends a row's drawn pixels (up to 8); empty rows are never queued.
// A QUEUE_DEPTH-entry queue between classifier and emitter absorbs input bursts.
// Reset: synchronous, active low; registers go to their reset values, queue and
// output are emptied.
module glyph_row_rasterizer #(
    parameter int QUEUE_DEPTH = grr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    grr_in_if.sink    i_in,
    grr_out_if.source o_out,
    grr_cfg_if.sink   i_cfg
);
    import grr_pkg::*;

    t_cfg regs;
    t_job push_job;
    t_job pop_job;
    logic push;
    logic q_full;
    logic q_valid;
    logic pop;

    grr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_regs  (regs)
    );

    grr_front u_front (
        .i_regs   (regs),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    grr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (pop_job)
    );

    grr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_regs    (regs),
        .i_q_valid (q_valid),
        .i_q_job   (pop_job),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule

FILE: rtl/grr_cfg.sv
module grr_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    grr_cfg_if.sink       i_cfg,
    output grr_pkg::t_cfg o_regs
);
    import grr_pkg::*;

    t_cfg r_regs;

    assign i_cfg.ready = 1'b1;
    assign o_regs      = r_regs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.font_height <= FONT_HEIGHT_RST;
            r_regs.scale       <= SCALE_RST;
            r_regs.clip_enable <= 1'b0;
            r_regs.clip_x      <= '0;
            r_regs.clip_y      <= '0;
            r_regs.clip_w      <= CLIP_DIM_RST;
            r_regs.clip_h      <= CLIP_DIM_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_FONT_HEIGHT: r_regs.font_height <= i_cfg.data[FONT_H_W-1:0];
                CFG_SCALE:       r_regs.scale       <= i_cfg.data[SCALE_W-1:0];
                CFG_CLIP_ENABLE: r_regs.clip_enable <= i_cfg.data[0];
                CFG_CLIP_X:      r_regs.clip_x      <= $signed(i_cfg.data[COORD_IN_W-1:0]);
                CFG_CLIP_Y:      r_regs.clip_y      <= $signed(i_cfg.data[COORD_IN_W-1:0]);
                CFG_CLIP_W:      r_regs.clip_w      <= i_cfg.data[CLIP_DIM_W-1:0];
                CFG_CLIP_H:      r_regs.clip_h      <= i_cfg.data[CLIP_DIM_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

FILE: rtl/grr_front.sv
module grr_front (
    input  grr_pkg::t_cfg i_regs,
    grr_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output grr_pkg::t_job o_job
);
    import grr_pkg::*;

    localparam int CW = COORD_OUT_W + 1;

    logic [NIBBLE_W-1:0]   w_sat;
    logic [7:0]            row_off;
    logic signed [CW-1:0]  py_w;
    logic signed [CW-1:0]  clip_l;
    logic signed [CW-1:0]  clip_r;
    logic signed [CW-1:0]  clip_t;
    logic signed [CW-1:0]  clip_b;
    logic                  y_ok;
    logic [ROW_PIXELS-1:0] kept;
    logic [6:0]            col_off;
    logic signed [CW-1:0]  px_w;

    always_comb begin
        w_sat   = (i_in.glyph_width > NIBBLE_W'(ROW_PIXELS)) ? NIBBLE_W'(ROW_PIXELS)
                                                              : i_in.glyph_width;
        row_off = i_in.row_index * i_regs.scale;
        py_w    = CW'(i_in.origin_y) + $signed({6'd0, row_off})
                + CW'(BASELINE_BIAS) - $signed({9'd0, i_regs.font_height});

        clip_l = CW'(i_regs.clip_x);
        clip_t = CW'(i_regs.clip_y);
        clip_r = CW'(i_regs.clip_x) + $signed({4'd0, i_regs.clip_w});
        clip_b = CW'(i_regs.clip_y) + $signed({4'd0, i_regs.clip_h});
        y_ok   = !i_regs.clip_enable || (py_w >= clip_t && py_w <= clip_b);

        // column c sits in bit 7-c; each column is tested on its own
        kept    = '0;
        col_off = '0;
        px_w    = '0;
        for (int c = 0; c < ROW_PIXELS; c++) begin
            col_off = 7'(c) * i_regs.scale;
            px_w    = CW'(i_in.origin_x) + $signed({7'd0, col_off});
            kept[ROW_PIXELS-1-c] = i_in.row_bits[ROW_PIXELS-1-c]
                                && (NIBBLE_W'(c) < w_sat) && y_ok
                                && (!i_regs.clip_enable
                                    || (px_w >= clip_l && px_w <= clip_r));
        end
    end

    assign i_in.ready = !i_q_full;
    // rows with nothing left to draw are consumed here and never queued
    assign o_push     = i_in.valid && !i_q_full && (kept != '0);
    assign o_job.ox   = i_in.origin_x;
    assign o_job.py   = py_w[COORD_OUT_W-1:0];
    assign o_job.mask = kept;

endmodule

FILE: rtl/grr_queue.sv
module grr_queue #(
    parameter int DEPTH = grr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  grr_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output grr_pkg::t_job o_job
);
    import grr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [NW-1:0] r_count;
    logic          push_ok;
    logic          pop_ok;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            case ({push_ok, pop_ok})
                2'b10:   r_count <= r_count + NW'(1);
                2'b01:   r_count <= r_count - NW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count above depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push_ok && !pop_ok) |=> (r_count == $past(r_count) + NW'(1)))
        else $error("queue count did not follow a lone push");

endmodule

FILE: rtl/grr_back.sv
module grr_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  grr_pkg::t_cfg i_regs,
    input  logic          i_q_valid,
    input  grr_pkg::t_job i_q_job,
    output logic          o_pop,
    grr_out_if.source     o_out
);
    import grr_pkg::*;

    logic                          r_busy;
    logic [ROW_PIXELS-1:0]         r_mask;
    logic signed [COORD_IN_W-1:0]  r_ox;
    logic signed [COORD_OUT_W-1:0] r_py;

    logic                          r_ovalid;
    logic signed [COORD_OUT_W-1:0] r_px_o;
    logic signed [COORD_OUT_W-1:0] r_py_o;
    logic [SCALE_W-1:0]            r_side_o;
    logic                          r_last_o;

    logic                          adv;
    logic                          last;
    logic [2:0]                    pos;
    logic [2:0]                    col;
    logic [6:0]                    col_off;
    logic [ROW_PIXELS-1:0]         rest;
    logic signed [COORD_OUT_W-1:0] px;

    always_comb begin
        // leftmost lit pixel is the highest set bit
        pos = '0;
        for (int i = 0; i < ROW_PIXELS; i++) begin
            if (r_mask[i]) begin
                pos = 3'(i);
            end
        end
        col     = ~pos;
        col_off = col * i_regs.scale;
        px      = COORD_OUT_W'(r_ox) + $signed({6'd0, col_off});
        rest    = r_mask & ~(ROW_PIXELS'(1) << pos);
        last    = (rest == '0);
        adv     = r_busy && (!r_ovalid || o_out.ready);
        o_pop   = i_q_valid && (!r_busy || (adv && last));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (adv && last) begin
                r_busy <= 1'b0;
            end
            if (adv) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mask <= i_q_job.mask;
            r_ox   <= i_q_job.ox;
            r_py   <= i_q_job.py;
        end else if (adv) begin
            r_mask <= rest;
        end
        if (adv) begin
            r_px_o   <= px;
            r_py_o   <= r_py;
            r_side_o <= i_regs.scale;
            r_last_o <= last;
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.pixel_x     = r_px_o;
    assign o_out.pixel_y     = r_py_o;
    assign o_out.square_side = r_side_o;
    assign o_out.last_in_row = r_last_o;

    a_busy_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_mask != '0))
        else $error("busy with no pixels left");

    a_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_busy)
        else $error("popped row not taken up");

    a_mid_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && !last) |=> (r_busy && r_ovalid && !r_last_o))
        else $error("row ended early");

endmodule

FILE: tb/grr_row_checker.sv
module grr_row_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    grr_in_if    i_row,
    grr_out_if   i_pix,
    grr_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_pending,
    output int   o_pixels,
    output int   o_dropped
);
    timeunit 1ns;
    timeprecision 1ps;

    import grr_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic signed [COORD_OUT_W-1:0] x;
        logic signed [COORD_OUT_W-1:0] y;
        logic [SCALE_W-1:0]            side;
        logic                          last;
    } t_lit_pixel;

    // shadow of the register file
    logic [FONT_H_W-1:0]          sh_font_height;
    logic [SCALE_W-1:0]           sh_scale;
    logic                         sh_clip_en;
    logic signed [COORD_IN_W-1:0] sh_clip_x;
    logic signed [COORD_IN_W-1:0] sh_clip_y;
    logic [CLIP_DIM_W-1:0]        sh_clip_w;
    logic [CLIP_DIM_W-1:0]        sh_clip_h;

    t_lit_pixel pixels_due[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_pixels  = 0;
        o_dropped = 0;
    end

    task automatic note_error(input string msg);
        o_errors++;
        if (o_errors <= REPORT_LIMIT) begin
            $display("[%0t] ERROR: %s", $realtime, msg);
        end
    endtask

    // expand one glyph row into the lit pixels that survive clipping, left to right
    function automatic void rasterise_row(input logic signed [COORD_IN_W-1:0] ox,
                                          input logic signed [COORD_IN_W-1:0] oy,
                                          input logic [NIBBLE_W-1:0] gw,
                                          input logic [NIBBLE_W-1:0] ri,
                                          input logic [ROW_PIXELS-1:0] bits);
        int         width;
        int         px;
        int         py;
        int         left;
        int         top;
        t_lit_pixel pix;
        t_lit_pixel row_pix[$];

        width = (int'(gw) > ROW_PIXELS) ? ROW_PIXELS : int'(gw);
        py = int'(oy) + int'(ri) * int'(sh_scale) + BASELINE_BIAS - int'(sh_font_height);
        left = int'(sh_clip_x);
        top  = int'(sh_clip_y);
        for (int col = 0; col < width; col++) begin
            if (bits[ROW_PIXELS-1-col]) begin
                px = int'(ox) + col * int'(sh_scale);
                if (sh_clip_en && (px < left || px > left + int'(sh_clip_w) ||
                                   py < top || py > top + int'(sh_clip_h))) begin
                    o_dropped++;
                end else begin
                    pix.x    = px[COORD_OUT_W-1:0];
                    pix.y    = py[COORD_OUT_W-1:0];
                    pix.side = sh_scale;
                    pix.last = 1'b0;
                    row_pix.push_back(pix);
                end
            end
        end
        if (row_pix.size() > 0) begin
            row_pix[row_pix.size()-1].last = 1'b1;
        end
        foreach (row_pix[i]) begin
            pixels_due.push_back(row_pix[i]);
        end
    endfunction

    always @(posedge i_clk) begin
        t_lit_pixel want;

        if (!i_rst_n) begin
            sh_font_height = FONT_HEIGHT_RST;
            sh_scale       = SCALE_RST;
            sh_clip_en     = 1'b0;
            sh_clip_x      = '0;
            sh_clip_y      = '0;
            sh_clip_w      = CLIP_DIM_RST;
            sh_clip_h      = CLIP_DIM_RST;
            pixels_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_FONT_HEIGHT: sh_font_height = i_cfg.data[FONT_H_W-1:0];
                    CFG_SCALE:       sh_scale       = i_cfg.data[SCALE_W-1:0];
                    CFG_CLIP_ENABLE: sh_clip_en     = i_cfg.data[0];
                    CFG_CLIP_X:      sh_clip_x      = i_cfg.data[COORD_IN_W-1:0];
                    CFG_CLIP_Y:      sh_clip_y      = i_cfg.data[COORD_IN_W-1:0];
                    CFG_CLIP_W:      sh_clip_w      = i_cfg.data[CLIP_DIM_W-1:0];
                    CFG_CLIP_H:      sh_clip_h      = i_cfg.data[CLIP_DIM_W-1:0];
                    default: ;
                endcase
            end
            if (i_row.valid && i_row.ready) begin
                rasterise_row(i_row.origin_x, i_row.origin_y, i_row.glyph_width,
                              i_row.row_index, i_row.row_bits);
            end
            if (i_pix.valid && i_pix.ready) begin
                o_pixels++;
                if (pixels_due.size() == 0) begin
                    note_error($sformatf("pixel with none due: x=%0d y=%0d side=%0d last=%0b",
                                         i_pix.pixel_x, i_pix.pixel_y, i_pix.square_side,
                                         i_pix.last_in_row));
                end else begin
                    want = pixels_due.pop_front();
                    if (i_pix.pixel_x !== want.x || i_pix.pixel_y !== want.y ||
                        i_pix.square_side !== want.side ||
                        i_pix.last_in_row !== want.last) begin
                        note_error({$sformatf("pixel mismatch: expected x=%0d y=%0d side=%0d last=%0b, ",
                                              want.x, want.y, want.side, want.last),
                                    $sformatf("got x=%0d y=%0d side=%0d last=%0b",
                                              i_pix.pixel_x, i_pix.pixel_y,
                                              i_pix.square_side, i_pix.last_in_row)});
                    end
                end
            end
        end
        o_pending = pixels_due.size();
    end

endmodule

FILE: tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import grr_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RX_HOLD_CYCLES = 150;
    localparam int HOLD_BURST     = 12;
    localparam int RAND_PHASES    = 7;
    localparam int ROWS_PER_PHASE = 13;
    localparam int LIMIT_NS       = 5_000_000;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    typedef struct packed {
        logic signed [COORD_IN_W-1:0] ox;
        logic signed [COORD_IN_W-1:0] oy;
        logic [NIBBLE_W-1:0]          gw;
        logic [NIBBLE_W-1:0]          ri;
        logic [ROW_PIXELS-1:0]        bits;
    } t_glyph_row;

    logic i_clk;
    logic i_rst_n;

    int chk_errors;
    int chk_pending;
    int chk_pixels;
    int chk_dropped;

    int rows_sent;
    int setups_done;
    int hold_reqs;
    int hold_done;
    int aim_x;
    int aim_y;

    grr_in_if  row_ch();
    grr_out_if pix_ch();
    grr_cfg_if cfg_ch();

    glyph_row_rasterizer u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (row_ch),
        .o_out   (pix_ch),
        .i_cfg   (cfg_ch)
    );

    grr_row_checker u_chk (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_row     (row_ch),
        .i_pix     (pix_ch),
        .i_cfg     (cfg_ch),
        .o_errors  (chk_errors),
        .o_pending (chk_pending),
        .o_pixels  (chk_pixels),
        .o_dropped (chk_dropped)
    );

    initial begin : clk_gen
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("*** FAILED ***");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // span 0: anywhere on screen; otherwise origins land near the aim point
    function automatic t_glyph_row random_row(input int span);
        t_glyph_row r;
        r.ox = COORD_IN_W'($urandom);
        r.oy = COORD_IN_W'($urandom);
        r.ri = NIBBLE_W'($urandom);
        if ($urandom_range(0, 9) < 8) begin
            r.gw   = NIBBLE_W'($urandom_range(1, 15));
            r.bits = ROW_PIXELS'($urandom_range(1, 255));
        end else begin
            r.gw   = NIBBLE_W'($urandom);
            r.bits = ROW_PIXELS'($urandom);
        end
        if (span > 0) begin
            r.ox = COORD_IN_W'(aim_x + int'($urandom_range(0, 2 * span)) - span);
            r.oy = COORD_IN_W'(aim_y + int'($urandom_range(0, 2 * span)) - span);
        end
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer,
    // valid left high so a following row can go back to back
    task automatic send_row(input t_glyph_row r, input int gap);
        if (gap > 0) begin
            row_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        row_ch.valid       <= 1'b1;
        row_ch.origin_x    <= r.ox;
        row_ch.origin_y    <= r.oy;
        row_ch.glyph_width <= r.gw;
        row_ch.row_index   <= r.ri;
        row_ch.row_bits    <= r.bits;
        @(posedge i_clk);
        while (!row_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        rows_sent++;
    endtask

    task automatic drive_row(input int ox, input int oy, input int gw, input int ri,
                             input int bits);
        t_glyph_row r;
        r.ox   = COORD_IN_W'(ox);
        r.oy   = COORD_IN_W'(oy);
        r.gw   = NIBBLE_W'(gw);
        r.ri   = NIBBLE_W'(ri);
        r.bits = ROW_PIXELS'(bits);
        send_row(r, pick_gap());
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= CFG_DATA_W'(val);
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // full register set, plus a write to the unused index which must be ignored
    task automatic apply_setup(input int fh, input int sc, input int en, input int cx,
                               input int cy, input int cw, input int chh);
        cfg_write(CFG_FONT_HEIGHT, fh);
        cfg_write(CFG_SCALE, sc);
        cfg_write(CFG_CLIP_ENABLE, en);
        cfg_write(CFG_CLIP_X, cx);
        cfg_write(CFG_CLIP_Y, cy);
        cfg_write(CFG_CLIP_W, cw);
        cfg_write(CFG_CLIP_H, chh);
        cfg_write(CFG_IDX_SPARE, $urandom);
        cfg_ch.valid <= 1'b0;
        aim_x = cx;
        aim_y = cy;
        setups_done++;
    endtask

    // empty rows leave nothing in the checker, so give the pipe time to drain
    task automatic settle();
        row_ch.valid <= 1'b0;
        while (chk_pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : pixel_sink
        int stall;
        int busy_pct;
        int cyc;
        pix_ch.ready = 1'b0;
        busy_pct = 0;
        cyc = 0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 64 == 0) begin
                busy_pct = 25 * $urandom_range(0, 2);
            end
            if (hold_reqs != hold_done) begin
                pix_ch.ready <= 1'b0;
                for (int n = 0; n < RX_HOLD_CYCLES; n++) @(negedge i_clk);
                hold_done++;
            end else if ($urandom_range(0, 99) < busy_pct) begin
                stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                   : $urandom_range(8, 30);
                pix_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pix_ch.ready <= 1'b1;
        end
    end

    initial begin : stimulus
        int         span;
        t_glyph_row burst_row;

        row_ch.valid       = 1'b0;
        row_ch.origin_x    = '0;
        row_ch.origin_y    = '0;
        row_ch.glyph_width = '0;
        row_ch.row_index   = '0;
        row_ch.row_bits    = '0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        rows_sent   = 0;
        setups_done = 0;
        hold_reqs   = 0;
        hold_done   = 0;
        aim_x       = 0;
        aim_y       = 0;
        i_rst_n     = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: empty rows, width saturation, coordinate extremes
        drive_row(0, 0, 8, 0, 8'h00);
        drive_row(5, 5, 0, 3, 8'hFF);
        drive_row(100, -50, 15, 2, 8'hFF);
        drive_row(-1024, -1024, 8, 0, 8'h81);
        drive_row(1023, 1023, 1, 15, 8'h80);
        drive_row(0, 0, 3, 1, 8'h1F);
        drive_row(-1, -1, 5, 7, 8'hA8);
        settle();

        apply_setup(16, 8, 0, 0, 0, 1023, 1023);
        drive_row(1023, 1023, 8, 15, 8'hFF);
        drive_row(-1024, -1024, 8, 15, 8'h55);
        settle();

        // zero scale: every pixel of the row on one corner
        apply_setup(31, 0, 0, 0, 0, 1023, 1023);
        drive_row(12, 34, 8, 5, 8'hFF);
        drive_row(-7, 3, 9, 0, 8'h3C);
        settle();

        apply_setup(0, 15, 0, 0, 0, 1023, 1023);
        drive_row(1023, -1024, 12, 15, 8'hFF);
        drive_row(0, 0, 8, 15, 8'h01);
        settle();

        // clip box x 10..16, y 20 only; font height 9 gives no baseline shift
        apply_setup(9, 2, 1, 10, 20, 6, 0);
        drive_row(10, 20, 8, 0, 8'hFF);
        drive_row(10, 21, 8, 0, 8'hFF);
        drive_row(4, 20, 8, 0, 8'hFF);
        drive_row(10, 18, 8, 1, 8'h80);
        drive_row(17, 20, 8, 0, 8'h80);
        drive_row(9, 19, 8, 0, 8'hFF);
        settle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            span = 0;
            case (ph)
                0: apply_setup($urandom_range(1, 16), $urandom_range(1, 8), 0,
                               $urandom, $urandom, $urandom, $urandom);
                1: begin
                    apply_setup(8, $urandom_range(1, 8), 1,
                                int'($urandom_range(0, 1600)) - 800,
                                int'($urandom_range(0, 1600)) - 800,
                                $urandom_range(0, 40), $urandom_range(0, 40));
                    span = 40;
                end
                2: apply_setup(16, 8, 1, -1024, -1024, 1023, 1023);
                3: apply_setup(0, 0, 0, $urandom, $urandom, $urandom, $urandom);
                4: apply_setup($urandom, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom);
                5: begin
                    apply_setup(31, 15, 1, 1023, 1023, 0, 0);
                    aim_y = 1000;
                    span = 30;
                end
                default: begin
                    apply_setup(1, 1, 1, int'($urandom_range(0, 1600)) - 800,
                                int'($urandom_range(0, 1600)) - 800,
                                $urandom_range(0, 12), $urandom_range(0, 12));
                    span = 16;
                end
            endcase
            if (ph == 2) begin
                // sink holds off while rows keep coming: queue fills, input stalls
                hold_reqs++;
                for (int n = 0; n < HOLD_BURST; n++) begin
                    // origins well inside the clip box so every row queues pixels
                    burst_row      = random_row(0);
                    burst_row.ox   = COORD_IN_W'(int'($urandom_range(0, 100)) - 1000);
                    burst_row.oy   = COORD_IN_W'(int'($urandom_range(0, 100)) - 1000);
                    burst_row.gw   = NIBBLE_W'(ROW_PIXELS);
                    burst_row.bits[ROW_PIXELS-1] = 1'b1;
                    send_row(burst_row, 0);
                end
            end
            for (int n = 0; n < ROWS_PER_PHASE; n++) begin
                send_row(random_row(span), pick_gap());
            end
            settle();
        end

        $display("Run covered %0d glyph rows over %0d register setups, %0d pixels compared.",
                 rows_sent, setups_done, chk_pixels);
        $display("%0d lit pixels fell outside the clip box and were dropped.", chk_dropped);
        if (chk_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/grr_pkg.sv
rtl/grr_intf.sv
rtl/grr_cfg.sv
rtl/grr_front.sv
rtl/grr_queue.sv
rtl/grr_back.sv
rtl/glyph_row_rasterizer.sv
tb/grr_row_checker.sv
tb/tb_top.sv
